/* design/keyed_track_table_with_expiry_top_defines.svh */
// Assertion macros for the keyed track table.
// Included by the top level; needs nothing else.
`ifndef KEYED_TRACK_TABLE_WITH_EXPIRY_TOP_DEFINES_SVH
`define KEYED_TRACK_TABLE_WITH_EXPIRY_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define KTE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KTE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define KTE_ASSERT(lbl, clk, rst_n, prop, msg)
`define KTE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

/* design/kte_pkg.sv */
// Shared types and codes for the keyed track table.
// No dependencies.
`default_nettype none
package kte_pkg;
    localparam int TRACK_SLOTS_DEF = 64;
    localparam int ADDR_W    = 24;
    localparam int STAMP_W   = 32;
    localparam int AGE_W     = 16;
    localparam int OUTCOME_W = 3;
    localparam int SLOT_W    = 6;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [OUTCOME_W-1:0] OUTCOME_HIT    = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FREE   = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT  = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUTCOME_REJECT = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUTCOME_SWEEP  = 3'd4;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_SWEEP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TTL     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE = 1'b1;

    localparam logic [STAMP_W-1:0] TTL_RESET     = 32'd60000;
    localparam logic [AGE_W-1:0]   MAX_AGE_RESET = 16'd600;

    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  address;
        logic [STAMP_W-1:0] stamp;
    } kte_entry_t;

    typedef struct packed {
        logic clr;  // start of a new scan
        logic vld;  // read word present this cycle
    } kte_scan_ctl_t;
endpackage
`default_nettype wire

/* design/kte_slot_eval.sv */
// Per-slot evaluation during a table scan: match, free, oldest and expiry.
// Depends on kte_pkg.
`default_nettype none
module kte_slot_eval import kte_pkg::*; #(
    parameter int TRACK_SLOTS = TRACK_SLOTS_DEF
) (
    input  wire                                           aclk,
    input  wire                                           aresetn,
    input  kte_scan_ctl_t                                 ctl,
    input  kte_entry_t                                    entry,
    input  wire [((TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1)-1:0] idx,
    input  wire [ADDR_W-1:0]                              key,
    input  wire [STAMP_W-1:0]                             now_ms,
    input  wire [STAMP_W-1:0]                             ttl_ms,
    output logic                                          exp_hit,
    output logic                                          match_found,
    output logic [((TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1)-1:0] match_idx,
    output logic                                          free_found,
    output logic [((TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1)-1:0] free_idx,
    output logic [((TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1)-1:0] oldest_idx,
    output logic [COUNT_W-1:0]                            exp_count
);
    localparam int IDX_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;

    logic               match_found_reg, match_found_next;
    logic [IDX_W-1:0]   match_idx_reg, match_idx_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]   oldest_idx_reg, oldest_idx_next;
    logic [STAMP_W-1:0] oldest_stamp_reg, oldest_stamp_next;
    logic [COUNT_W-1:0] exp_count_reg, exp_count_next;
    logic [STAMP_W-1:0] age;

    // Wrap-safe age of the slot.
    assign age     = now_ms - entry.stamp;
    assign exp_hit = ctl.vld && entry.valid && (age > ttl_ms);

    always_comb begin
        match_found_next  = match_found_reg;
        match_idx_next    = match_idx_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        oldest_idx_next   = oldest_idx_reg;
        oldest_stamp_next = oldest_stamp_reg;
        exp_count_next    = exp_count_reg;
        if (ctl.clr) begin
            match_found_next  = 1'b0;
            free_found_next   = 1'b0;
            oldest_idx_next   = '0;
            oldest_stamp_next = '1;
            exp_count_next    = '0;
        end else if (ctl.vld) begin
            // keep the lowest index for match and free
            if (entry.valid && entry.address == key && !match_found_reg) begin
                match_found_next = 1'b1;
                match_idx_next   = idx;
            end
            if (!entry.valid && !free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = idx;
            end
            if (entry.stamp < oldest_stamp_reg) begin
                oldest_idx_next   = idx;
                oldest_stamp_next = entry.stamp;
            end
            if (exp_hit && exp_count_reg != '1) begin
                exp_count_next = exp_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            exp_count_reg   <= '0;
        end else begin
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            exp_count_reg   <= exp_count_next;
        end
        match_idx_reg    <= match_idx_next;
        free_idx_reg     <= free_idx_next;
        oldest_idx_reg   <= oldest_idx_next;
        oldest_stamp_reg <= oldest_stamp_next;
    end

    assign match_found = match_found_reg;
    assign match_idx   = match_idx_reg;
    assign free_found  = free_found_reg;
    assign free_idx    = free_idx_reg;
    assign oldest_idx  = oldest_idx_reg;
    assign exp_count   = exp_count_reg;
endmodule
`default_nettype wire

/* design/keyed_track_table_with_expiry_top.sv */
// Keyed track table with expiry: usage notes.
// Input stream s_*: one word per report or sweep; s_tuser selects the kind.
// Output stream m_*: one word per input word, in order; m_tuser is the outcome.
// Config port: cfg_we/cfg_addr/cfg_wdata, register 0 time-to-live in ms,
// register 1 largest accepted report age in tenths of a second.
// After reset the block runs a clearing pass over all TRACK_SLOTS slots (64 by
// default) of the slot memory with s_tready low; config writes still land.
// A rejected report skips the scan and goes straight to the result state.
// An accepted report or a sweep scans every slot through the single memory read
// port, one slot per cycle, then passes through an update state before its result.
// One word is worked on at a time; s_tready is high only when idle.
// A stalled result sits in the output register; the block takes the next input
// word meanwhile and holds its own result until the register frees up.
// Depends on kte_pkg, kte_slot_eval and the defines header.
`default_nettype none
`include "keyed_track_table_with_expiry_top_defines.svh"
module keyed_track_table_with_expiry_top import kte_pkg::*; #(
    parameter int TRACK_SLOTS = TRACK_SLOTS_DEF
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    // [23:0] address, [24] has_position, [40:25] report_age_tenths,
    // [72:41] now_ms, [79:73] zero
    input  wire [79:0]            s_tdata,
    // [0] kind
    input  wire                   s_tuser,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    // [5:0] slot, [12:6] expired_count, [13] any_expired, [15:14] zero
    output logic [15:0]           m_tdata,
    // [2:0] outcome
    output logic [OUTCOME_W-1:0]  m_tuser,
    input  wire                   cfg_we,
    input  wire [CFG_IDX_W-1:0]   cfg_addr,
    input  wire [CFG_DATA_W-1:0]  cfg_wdata
);
    localparam int IDX_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam logic [IDX_W:0]   SLOT_CNT = (IDX_W + 1)'(TRACK_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRACK_SLOTS - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [IDX_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [IDX_W:0]       rd_cnt_reg, rd_cnt_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]     rd_pidx_reg, rd_pidx_next;

    logic [STAMP_W-1:0]   ttl_reg;
    logic [AGE_W-1:0]     max_age_reg;

    logic                 it_sweep_reg;
    logic [ADDR_W-1:0]    it_addr_reg;
    logic [STAMP_W-1:0]   it_now_reg;

    logic [OUTCOME_W-1:0] res_outcome_reg, res_outcome_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [COUNT_W-1:0]   res_count_reg, res_count_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [15:0]          m_tdata_reg, m_tdata_next;
    logic [OUTCOME_W-1:0] m_tuser_reg, m_tuser_next;

    kte_entry_t           mem [TRACK_SLOTS];
    kte_entry_t           mem_rdata_reg;
    kte_entry_t           mem_wdata;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [IDX_W-1:0]     mem_raddr;

    kte_scan_ctl_t        scan_ctl;
    logic                 exp_hit;
    logic                 match_found;
    logic                 free_found;
    logic [IDX_W-1:0]     match_idx;
    logic [IDX_W-1:0]     free_idx;
    logic [IDX_W-1:0]     oldest_idx;
    logic [COUNT_W-1:0]   exp_count;
    logic [IDX_W-1:0]     chosen;
    logic [IDX_W+SLOT_W-1:0] chosen_ext;

    logic                 s_accept;
    logic                 in_sweep;
    logic                 in_has_pos;
    logic [AGE_W-1:0]     in_age;

    assign s_accept   = s_tvalid && s_tready;
    assign in_sweep   = (s_tuser == KIND_SWEEP);
    assign in_has_pos = s_tdata[24];
    assign in_age     = s_tdata[40:25];
    assign s_tready   = (state_reg == ST_IDLE);

    kte_slot_eval #(
        .TRACK_SLOTS (TRACK_SLOTS)
    ) u_eval (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (scan_ctl),
        .entry       (mem_rdata_reg),
        .idx         (rd_pidx_reg),
        .key         (it_addr_reg),
        .now_ms      (it_now_reg),
        .ttl_ms      (ttl_reg),
        .exp_hit     (exp_hit),
        .match_found (match_found),
        .match_idx   (match_idx),
        .free_found  (free_found),
        .free_idx    (free_idx),
        .oldest_idx  (oldest_idx),
        .exp_count   (exp_count)
    );

    // Slot memory: one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_comb begin
        if (match_found) begin
            chosen = match_idx;
        end else if (free_found) begin
            chosen = free_idx;
        end else begin
            chosen = oldest_idx;
        end
        chosen_ext = {{SLOT_W{1'b0}}, chosen};
    end

    always_comb begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        rd_cnt_next      = rd_cnt_reg;
        rd_pend_next     = 1'b0;
        rd_pidx_next     = rd_cnt_reg[IDX_W-1:0];
        mem_raddr        = rd_cnt_reg[IDX_W-1:0];
        mem_we           = 1'b0;
        mem_waddr        = rd_pidx_reg;
        mem_wdata        = mem_rdata_reg;
        scan_ctl.clr     = 1'b0;
        scan_ctl.vld     = 1'b0;
        res_outcome_next = res_outcome_reg;
        res_slot_next    = res_slot_reg;
        res_count_next   = res_count_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    if (in_sweep || (in_has_pos && in_age <= max_age_reg)) begin
                        state_next   = ST_SCAN;
                        rd_cnt_next  = '0;
                        scan_ctl.clr = 1'b1;
                    end else begin
                        res_outcome_next = OUTCOME_REJECT;
                        res_slot_next    = '0;
                        res_count_next   = '0;
                        state_next       = ST_RESULT;
                    end
                end
            end
            ST_SCAN: begin
                // issue one read per cycle, evaluate the word in the next cycle
                if (rd_cnt_reg != SLOT_CNT) begin
                    rd_pend_next = 1'b1;
                    rd_cnt_next  = rd_cnt_reg + 1'b1;
                end
                if (rd_pend_reg) begin
                    scan_ctl.vld = 1'b1;
                    if (it_sweep_reg && exp_hit) begin
                        mem_we          = 1'b1;
                        mem_wdata.valid = 1'b0;
                    end
                    if (rd_pidx_reg == LAST_IDX) begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                if (it_sweep_reg) begin
                    res_outcome_next = OUTCOME_SWEEP;
                    res_slot_next    = '0;
                    res_count_next   = exp_count;
                end else begin
                    mem_we           = 1'b1;
                    mem_waddr        = chosen;
                    mem_wdata.valid  = 1'b1;
                    mem_wdata.address = it_addr_reg;
                    mem_wdata.stamp  = it_now_reg;
                    if (match_found) begin
                        res_outcome_next = OUTCOME_HIT;
                    end else if (free_found) begin
                        res_outcome_next = OUTCOME_FREE;
                    end else begin
                        res_outcome_next = OUTCOME_EVICT;
                    end
                    res_slot_next  = chosen_ext[SLOT_W-1:0];
                    res_count_next = '0;
                end
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_outcome_reg;
                    m_tdata_next  = {2'b00, (res_count_reg != '0), res_count_reg,
                                     res_slot_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            rd_cnt_reg   <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            rd_cnt_reg   <= rd_cnt_next;
            rd_pend_reg  <= rd_pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        rd_pidx_reg     <= rd_pidx_next;
        res_outcome_reg <= res_outcome_next;
        res_slot_reg    <= res_slot_next;
        res_count_reg   <= res_count_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;
        if (s_accept) begin
            it_sweep_reg <= in_sweep;
            it_addr_reg  <= s_tdata[23:0];
            it_now_reg   <= s_tdata[72:41];
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ttl_reg     <= TTL_RESET;
            max_age_reg <= MAX_AGE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_TTL:     ttl_reg     <= cfg_wdata;
                REG_MAX_AGE: max_age_reg <= cfg_wdata[AGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `KTE_ASSERT(a_sweep_no_slot, aclk, aresetn,
        (m_tvalid && m_tuser == OUTCOME_SWEEP) |-> (m_tdata[5:0] == '0),
        "sweep result carries a slot index")
    `KTE_ASSERT(a_report_no_count, aclk, aresetn,
        (m_tvalid && (m_tuser == OUTCOME_HIT || m_tuser == OUTCOME_FREE || m_tuser == OUTCOME_EVICT || m_tuser == OUTCOME_REJECT)) |-> (m_tdata[13:6] == '0),
        "report result carries an expiry count")
    `KTE_ASSERT(a_report_scan_no_write, aclk, aresetn,
        (state_reg == ST_SCAN && !it_sweep_reg) |-> !mem_we,
        "slot memory written during a report scan")
    `KTE_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn,
        s_accept, !s_tready,
        "new word taken while one is still in work")
endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for keyed_track_table_with_expiry_top: directed table, then
// randomized phases of reports and sweeps checked against a built-in slot table predictor.
// Depends on kte_pkg and the RTL under design/.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import kte_pkg::*;

    localparam int SLOTS          = TRACK_SLOTS_DEF;
    localparam int RX_HOLD_CYCLES = 600;
    // longest quiet stretch: clearing pass, long hold-off, one full scan
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_TAIL     = 80;
    localparam int DIR_N          = 21;

    typedef struct packed {
        logic               kind;
        logic [ADDR_W-1:0]  addr;
        logic               has_pos;
        logic [AGE_W-1:0]   age;
        logic [STAMP_W-1:0] now;
    } track_word_t;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [SLOT_W-1:0]    slot;
        logic [COUNT_W-1:0]   expired;
        logic                 any_exp;
    } track_result_t;

    typedef struct packed {
        track_word_t   w;
        logic          known;
        track_result_t res;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [79:0]           s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic [OUTCOME_W-1:0]  m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor state
    logic               tbl_valid [SLOTS];
    logic [ADDR_W-1:0]  tbl_addr  [SLOTS];
    logic [STAMP_W-1:0] tbl_stamp [SLOTS];
    logic [STAMP_W-1:0] ttl_ms  = TTL_RESET;
    logic [AGE_W-1:0]   max_age = MAX_AGE_RESET;

    track_result_t pending_results [$];
    int            errors = 0;
    int            stall_cycles = 0;
    bit            quiet_run = 1'b0;
    bit            rx_hold_req = 1'b0;

    // random stimulus shaping
    logic [ADDR_W-1:0]  addr_pool [128];
    int                 pool_n = 1;
    int                 step_max = 1;
    int                 sweep_pct = 10;
    logic [STAMP_W-1:0] now_cursor = '0;

    dir_row_t dir_rows [DIR_N] = '{
        '{'{KIND_REPORT, 24'h000000, 1'b1, 16'd0,     32'd0},
          1'b1, '{OUTCOME_FREE,   6'd0, 7'd0, 1'b0}},
        '{'{KIND_REPORT, 24'hFFFFFF, 1'b1, 16'd600,   32'd1000},
          1'b1, '{OUTCOME_FREE,   6'd1, 7'd0, 1'b0}},
        '{'{KIND_REPORT, 24'hABCDEF, 1'b1, 16'd601,   32'd2000},
          1'b1, '{OUTCOME_REJECT, 6'd0, 7'd0, 1'b0}},
        '{'{KIND_REPORT, 24'h123456, 1'b0, 16'd0,     32'd3000},
          1'b1, '{OUTCOME_REJECT, 6'd0, 7'd0, 1'b0}},
        '{'{KIND_REPORT, 24'h123456, 1'b0, 16'hFFFF,  32'd3500},
          1'b1, '{OUTCOME_REJECT, 6'd0, 7'd0, 1'b0}},
        '{'{KIND_REPORT, 24'h000000, 1'b1, 16'd100,   32'd5000},
          1'b1, '{OUTCOME_HIT,    6'd0, 7'd0, 1'b0}},
        '{'{KIND_REPORT, 24'h123456, 1'b1, 16'hFFFF,  32'd6000},
          1'b1, '{OUTCOME_REJECT, 6'd0, 7'd0, 1'b0}},
        '{'{KIND_REPORT, 24'h555555, 1'b1, 16'd300,   32'd10000},
          1'b1, '{OUTCOME_FREE,   6'd2, 7'd0, 1'b0}},
        '{'{KIND_SWEEP,  24'h000000, 1'b0, 16'd0,     32'd60000},
          1'b1, '{OUTCOME_SWEEP,  6'd0, 7'd0, 1'b0}},
        // age equal to the time-to-live stays
        '{'{KIND_SWEEP,  24'h000000, 1'b0, 16'd0,     32'd61000},
          1'b1, '{OUTCOME_SWEEP,  6'd0, 7'd0, 1'b0}},
        '{'{KIND_SWEEP,  24'h000000, 1'b0, 16'd0,     32'd61001},
          1'b1, '{OUTCOME_SWEEP,  6'd0, 7'd1, 1'b1}},
        '{'{KIND_REPORT, 24'hFFFFFF, 1'b1, 16'd0,     32'd61500},
          1'b1, '{OUTCOME_FREE,   6'd1, 7'd0, 1'b0}},
        '{'{KIND_REPORT, 24'hAAAAAA, 1'b1, 16'd50,    32'hFFFFFFFF},
          1'b1, '{OUTCOME_FREE,   6'd3, 7'd0, 1'b0}},
        // timer wrapped: the slot stamped at the top stays young
        '{'{KIND_SWEEP,  24'h000000, 1'b0, 16'd0,     32'h00000100},
          1'b1, '{OUTCOME_SWEEP,  6'd0, 7'd3, 1'b1}},
        '{'{KIND_REPORT, 24'hAAAAAA, 1'b1, 16'd600,   32'h00000200},
          1'b1, '{OUTCOME_HIT,    6'd3, 7'd0, 1'b0}},
        '{'{KIND_SWEEP,  24'hFFFFFF, 1'b1, 16'hFFFF,  32'h00000300},
          1'b1, '{OUTCOME_SWEEP,  6'd0, 7'd0, 1'b0}},
        '{'{KIND_REPORT, 24'h000001, 1'b1, 16'd1,     32'h80000000},
          1'b1, '{OUTCOME_FREE,   6'd0, 7'd0, 1'b0}},
        '{'{KIND_SWEEP,  24'h000000, 1'b0, 16'd0,     32'h8000EA61},
          1'b1, '{OUTCOME_SWEEP,  6'd0, 7'd2, 1'b1}},
        '{'{KIND_REPORT, 24'h00F00F, 1'b1, 16'd599,   32'h8000F000},
          1'b0, '0},
        '{'{KIND_REPORT, 24'h00F00F, 1'b1, 16'd600,   32'h8000F100},
          1'b0, '0},
        '{'{KIND_SWEEP,  24'h000000, 1'b0, 16'd0,     32'h00000000},
          1'b0, '0}
    };

    keyed_track_table_with_expiry_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    function automatic track_result_t predict_track(input track_word_t w);
        track_result_t      r;
        int                 chosen;
        int unsigned        freed;
        logic [STAMP_W-1:0] age_ms;
        r = '0;
        freed = 0;
        chosen = -1;
        if (w.kind == KIND_SWEEP) begin
            for (int i = 0; i < SLOTS; i++) begin
                age_ms = w.now - tbl_stamp[i];
                if (tbl_valid[i] && age_ms > ttl_ms) begin
                    tbl_valid[i] = 1'b0;
                    freed++;
                end
            end
            r.outcome = OUTCOME_SWEEP;
            r.expired = (freed > 127) ? 7'd127 : freed[COUNT_W-1:0];
            r.any_exp = (freed != 0);
        end else if (!w.has_pos || w.age > max_age) begin
            r.outcome = OUTCOME_REJECT;
        end else begin
            r.outcome = OUTCOME_HIT;
            for (int i = 0; i < SLOTS && chosen < 0; i++)
                if (tbl_valid[i] && tbl_addr[i] == w.addr) chosen = i;
            if (chosen < 0) begin
                r.outcome = OUTCOME_FREE;
                for (int i = 0; i < SLOTS && chosen < 0; i++)
                    if (!tbl_valid[i]) chosen = i;
            end
            // full table: plain smallest stamp, lowest index on ties
            if (chosen < 0) begin
                r.outcome = OUTCOME_EVICT;
                chosen = 0;
                for (int i = 1; i < SLOTS; i++)
                    if (tbl_stamp[i] < tbl_stamp[chosen]) chosen = i;
            end
            tbl_valid[chosen] = 1'b1;
            tbl_addr[chosen]  = w.addr;
            tbl_stamp[chosen] = w.now;
            r.slot = chosen[SLOT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [AGE_W-1:0] pick_age();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 13) return AGE_W'($urandom_range(0, int'(max_age)));
        else if (sel < 17) return AGE_W'($urandom());
        else if (sel < 19) return max_age;
        else return max_age + 16'd1;
    endfunction

    function automatic track_word_t next_word();
        track_word_t w;
        w.kind    = ($urandom_range(0, 99) < sweep_pct) ? KIND_SWEEP : KIND_REPORT;
        w.addr    = ($urandom_range(0, 9) < 7) ? addr_pool[$urandom_range(0, pool_n - 1)]
                                               : ADDR_W'($urandom());
        w.has_pos = ($urandom_range(0, 99) < 92);
        w.age     = pick_age();
        if ($urandom_range(0, 32) == 0) now_cursor = $urandom();
        else now_cursor = now_cursor + STAMP_W'($urandom_range(0, step_max));
        w.now     = now_cursor;
        return w;
    endfunction

    // Offer one word and hold it until taken; log its expected result.
    task automatic send_word(input track_word_t w, input logic known,
                             input track_result_t known_res);
        track_result_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= w.kind;
        s_tdata  <= {7'b0, w.now, w.age, w.has_pos, w.addr};
        do @(posedge aclk); while (!s_tready);
        r = predict_track(w);
        pending_results.push_back(known ? known_res : r);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [31:0] ttl_val, input logic [31:0] age_raw);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_TTL;
        cfg_wdata <= ttl_val;
        @(posedge aclk);
        cfg_addr  <= REG_MAX_AGE;
        cfg_wdata <= age_raw;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        ttl_ms  = ttl_val;
        max_age = age_raw[AGE_W-1:0];
    endtask

    task automatic run_phase(input int n, input int pool_sz, input int step,
                             input int sweeps, input int hold_at, input int pause_at,
                             input logic [STAMP_W-1:0] now_start);
        track_word_t w;
        int          gap;
        pool_n     = pool_sz;
        step_max   = step;
        sweep_pct  = sweeps;
        now_cursor = now_start;
        for (int i = 0; i < pool_sz; i++) addr_pool[i] = ADDR_W'($urandom());
        for (int i = 0; i < n; i++) begin
            w = next_word();
            send_word(w, 1'b0, '0);
            if (i == hold_at) rx_hold_req = 1'b1;
            if (i == pause_at) begin
                drain_results();
            end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 15);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        drain_results();
    endtask

    // result side: random stall bursts, one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (!quiet_run && $urandom_range(0, 11) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        track_result_t got;
        track_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[5:0], m_tdata[12:6], m_tdata[13]};
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word outcome=%0d slot=%0d count=%0d any=%0d",
                         $time, got.outcome, got.slot, got.expired, got.any_exp);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch expected outcome=%0d slot=%0d count=%0d any=%0d, actual outcome=%0d slot=%0d count=%0d any=%0d",
                             $time, want.outcome, want.slot, want.expired, want.any_exp,
                             got.outcome, got.slot, got.expired, got.any_exp);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
        else stall_cycles++;
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("%0t: timeout, no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[keyed_track_table_with_expiry_top] ERROR");
        $finish;
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_addr[i]  = '0;
            tbl_stamp[i] = '0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset register values are in effect for the directed rows
        foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].known, dir_rows[i].res);
        drain_results();

        // both limits at zero: only zero ages pass, any aged slot expires
        write_regs(32'd0, 32'd0);
        run_phase(300, 20, 5, 10, -1, 150, 32'd1000);

        // limits at the top, excess bits on the age register; no sweeps, so the
        // table fills and evicts across the timer wrap
        write_regs(32'hFFFFFFFF, {16'($urandom()), 16'hFFFF});
        run_phase(500, 120, 40, 0, 100, 300, 32'hFFFFFF00);

        write_regs($urandom_range(2000, 200000), $urandom_range(0, 2000));
        run_phase(500, 80, 2000, 12, -1, -1, 32'hFFFE0000);

        quiet_run = 1'b1;
        write_regs($urandom_range(0, 50000), $urandom());
        run_phase(500, 70, 1500, 10, -1, -1, $urandom());

        repeat (DRAIN_TAIL) @(posedge aclk);
        if (errors == 0) begin
            $display("[keyed_track_table_with_expiry_top] OK");
        end else begin
            $display("[keyed_track_table_with_expiry_top] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
